// ===== design/quaternion_product_rotate_unit_macros.svh =====
// Assertion macros used by the quaternion unit's top-level RTL file.
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_MACROS_SVH

// A property that must hold in the same cycle as its trigger.
`define QPR_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("qpr: same-cycle check failed");

// A property that must hold in the cycle after its trigger.
`define QPR_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("qpr: next-cycle check failed");

`endif

// ===== design/qpr_pkg.sv =====
// Package with the shared constants and operation codes of the quaternion unit.
`default_nettype none

package qpr_pkg;

  localparam int WORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Extra bits kept in the intermediate rotation product.
  localparam int GUARD_BITS = 4;

  typedef enum logic [1:0] {
    KIND_PRODUCT = 2'd0,
    KIND_ROTATE  = 2'd1,
    KIND_CONJ    = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// ===== design/qpr_mul.sv =====
// Registered four by four array of signed multipliers for one Hamilton product.
`default_nettype none

module qpr_mul #(
  parameter int P_BITS = qpr_pkg::WORD_BITS_DEF,
  parameter int Q_BITS = qpr_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             adv,
  input  logic signed [P_BITS-1:0]         p      [4],
  input  logic signed [Q_BITS-1:0]         q      [4],
  output logic signed [P_BITS+Q_BITS-1:0]  prod_r [16]
);

  // Entry 4*i+j holds p[i] times q[j], exact.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[4*i+j] <= p[i] * q[j];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/qpr_sum.sv =====
// Signed combination of sixteen partial products into a rounded quaternion.
`default_nettype none

module qpr_sum #(
  parameter int P_BITS    = 2 * qpr_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF,
  parameter bit CONJ      = 1'b0
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic signed [P_BITS-1:0]  prod  [16],
  output logic signed [P_BITS+1:0]  sum_r [4]
);

  localparam int S_BITS = P_BITS + 2;
  localparam logic signed [S_BITS-1:0] HALF = S_BITS'(1) << (FRAC_BITS - 1);

  logic signed [S_BITS-1:0] e   [16];
  logic signed [S_BITS-1:0] acc [4];

  // When the right operand is a conjugate, every term from its vector part flips sign.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (CONJ && (j != 0)) begin
          e[4*i+j] = -S_BITS'(prod[4*i+j]);
        end else begin
          e[4*i+j] = S_BITS'(prod[4*i+j]);
        end
      end
    end
    acc[0] = e[0] - e[5]  - e[10] - e[15] + HALF;
    acc[1] = e[1] + e[4]  + e[11] - e[14] + HALF;
    acc[2] = e[2] - e[7]  + e[8]  + e[13] + HALF;
    acc[3] = e[3] + e[6]  - e[9]  + e[12] + HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= acc[k] >>> FRAC_BITS;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/quaternion_product_rotate_unit.sv =====
// Top level of the pipelined fixed-point quaternion product and rotation unit.
//
//  Channel   Direction  Handshake              Word
//  in_*      input      in_valid / in_stall    kind, quaternion A, operand B
//  out_*     output     out_valid / out_stall  result quaternion and clip flag
//
// A word passes five register stages, and one word can enter in every cycle
// that the pipe is not held by a stall; the stages are multiply, sum and round,
// multiply by the conjugate, sum and round, then select and saturate into the
// output register.
// Reset is synchronous and active low; it clears only the stage valid bits.
// A stall on the output while a word waits there freezes all stages at once, so nothing is lost or
// repeated, and in_stall follows from the output register and out_stall alone.
`default_nettype none

`include "quaternion_product_rotate_unit_macros.svh"

module quaternion_product_rotate_unit #(
  parameter int WORD_BITS = qpr_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic signed [WORD_BITS-1:0] in_a_w,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_b_w,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_r_w,
  output logic signed [WORD_BITS-1:0] out_r_x,
  output logic signed [WORD_BITS-1:0] out_r_y,
  output logic signed [WORD_BITS-1:0] out_r_z,
  output logic                        out_clipped
);

  import qpr_pkg::*;

  localparam int W        = WORD_BITS;
  localparam int T_BITS   = W + GUARD_BITS;
  localparam int P1_BITS  = 2 * W;
  localparam int S1_BITS  = P1_BITS + 2;
  localparam int P2_BITS  = T_BITS + W;
  localparam int SAT_BITS = P2_BITS + 2;

  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  // Valid bit of each stage; bit 4 is the output register.
  logic [4:0] vld_r;

  // The whole pipe moves together unless a finished word waits on a stalled output.
  logic adv;
  assign adv      = !(vld_r[4] && out_stall);
  assign in_stall = !adv;

  // Sideband that travels with each word through stages one to four.
  logic [1:0]                kind_r [4];
  logic signed [W-1:0]       a_r    [4][4];
  // Rounded Hamilton product A*B, carried from stage two to the output stage.
  logic signed [S1_BITS-1:0] prd_r  [2][4];

  logic signed [W-1:0]        a_in   [4];
  logic signed [W-1:0]        b_in   [4];
  logic signed [P1_BITS-1:0]  m1     [16];
  logic signed [S1_BITS-1:0]  s1     [4];
  logic signed [T_BITS-1:0]   t      [4];
  logic signed [P2_BITS-1:0]  m2     [16];
  logic signed [SAT_BITS-1:0] s2     [4];

  logic signed [SAT_BITS-1:0] v      [4];
  logic signed [W-1:0]        r      [4];
  logic                       clip;
  logic signed [W-1:0]        out_r_r [4];
  logic                       out_clip_r;
  logic [1:0]                 out_kind_r;

  // For a rotation the operand is the pure quaternion (0, v), so its scalar part is dropped.
  always_comb begin
    a_in[0] = in_a_w;
    a_in[1] = in_a_x;
    a_in[2] = in_a_y;
    a_in[3] = in_a_z;
    b_in[0] = (in_kind == KIND_ROTATE) ? '0 : in_b_w;
    b_in[1] = in_b_x;
    b_in[2] = in_b_y;
    b_in[3] = in_b_z;
  end

  qpr_mul #(
    .P_BITS (W),
    .Q_BITS (W)
  ) u_mul_ab (
    .clk    (clk),
    .adv    (adv),
    .p      (a_in),
    .q      (b_in),
    .prod_r (m1)
  );

  qpr_sum #(
    .P_BITS    (P1_BITS),
    .FRAC_BITS (FRAC_BITS),
    .CONJ      (1'b0)
  ) u_sum_ab (
    .clk   (clk),
    .adv   (adv),
    .prod  (m1),
    .sum_r (s1)
  );

  // The intermediate rotation product wraps at T_BITS without saturation.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t[k] = s1[k][T_BITS-1:0];
    end
  end

  qpr_mul #(
    .P_BITS (T_BITS),
    .Q_BITS (W)
  ) u_mul_tc (
    .clk    (clk),
    .adv    (adv),
    .p      (t),
    .q      (a_r[1]),
    .prod_r (m2)
  );

  // Multiplying by conj(A) is done with plain A and sign flips in the adder.
  qpr_sum #(
    .P_BITS    (P2_BITS),
    .FRAC_BITS (FRAC_BITS),
    .CONJ      (1'b1)
  ) u_sum_tc (
    .clk   (clk),
    .adv   (adv),
    .prod  (m2),
    .sum_r (s2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[0] <= in_kind;
      a_r[0]    <= a_in;
      for (int s = 1; s < 4; s++) begin
        kind_r[s] <= kind_r[s-1];
        a_r[s]    <= a_r[s-1];
      end
      prd_r[0] <= s1;
      prd_r[1] <= prd_r[0];
    end
  end

  // Pick the full-width value of each component, then saturate to the word range.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v[k] = '0;
    end
    unique case (kind_r[3])
      KIND_PRODUCT: begin
        for (int k = 0; k < 4; k++) begin
          v[k] = SAT_BITS'(prd_r[1][k]);
        end
      end
      KIND_ROTATE: begin
        for (int k = 1; k < 4; k++) begin
          v[k] = s2[k];
        end
      end
      KIND_CONJ: begin
        v[0] = SAT_BITS'(a_r[3][0]);
        for (int k = 1; k < 4; k++) begin
          v[k] = -SAT_BITS'(a_r[3][k]);
        end
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          v[k] = '0;
        end
      end
    endcase
    clip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((&v[k][SAT_BITS-1:W-1]) || !(|v[k][SAT_BITS-1:W-1])) begin
        r[k] = v[k][W-1:0];
      end else begin
        r[k] = v[k][SAT_BITS-1] ? MIN_VAL : MAX_VAL;
        clip = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r_r    <= r;
      out_clip_r <= clip;
      out_kind_r <= kind_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  assign out_valid   = vld_r[4];
  assign out_r_w     = out_r_r[0];
  assign out_r_x     = out_r_r[1];
  assign out_r_y     = out_r_r[2];
  assign out_r_z     = out_r_r[3];
  assign out_clipped = out_clip_r;

  `QPR_ASSERT_NEXT(a_word_enters, in_valid && !in_stall, vld_r[0])
  `QPR_ASSERT_NEXT(a_word_drains, vld_r[3] && adv, out_valid)
  `QPR_ASSERT_NEXT(a_stage_holds, vld_r[2] && !adv, vld_r[2])
  `QPR_ASSERT_NOW(a_rotate_scalar_zero, out_valid && out_kind_r == KIND_ROTATE, out_r_w == '0)
  `QPR_ASSERT_NOW(a_unused_kind_zero, out_valid && (&out_kind_r), !out_clipped && out_r_x == '0)

endmodule

`default_nettype wire
